>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBLC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBLC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sblc_pkg.sv
// Types and codes shared by the size-budgeted LRU cache modules.
package sblc_pkg;

  typedef struct packed {
    logic [31:0] key_id;
    logic [31:0] item_size;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        stored;
    logic [4:0]  evicted_count;
    logic [31:0] bytes_in_use;
  } out_t;

  typedef enum logic [2:0] {
    ALU_ADD = 3'b001,
    ALU_SUB = 3'b010,
    ALU_CHK = 3'b100
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] limit;
  } alu_req_t;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LK_RD  = 13'b0000000000010,
    S_LK_CHK = 13'b0000000000100,
    S_FD_RD  = 13'b0000000001000,
    S_FD_CHK = 13'b0000000010000,
    S_EV_RD  = 13'b0000000100000,
    S_EV_CHK = 13'b0000001000000,
    S_EV_SUB = 13'b0000010000000,
    S_FR_RD  = 13'b0000100000000,
    S_FR_CHK = 13'b0001000000000,
    S_SH_RD  = 13'b0010000000000,
    S_SH_WR  = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  localparam logic [31:0] BUDGET_RESET = 32'd65536;

endpackage

>>> sv/sblc_alu.sv
// Shared adder/subtractor with budget compare.
module sblc_alu import sblc_pkg::*; (
  input  alu_req_t    req,
  output logic [31:0] res,
  output logic        over
);

  logic [32:0] sum;

  assign sum  = {1'b0, req.a} + {1'b0, req.b};
  // compared at 33 bits so the sum never wraps
  assign over = sum > {1'b0, req.limit};

  always_comb begin
    unique case (req.op)
      ALU_ADD: res = sum[31:0];
      ALU_SUB: res = req.a - req.b;
      ALU_CHK: res = sum[31:0];
      default: res = sum[31:0];
    endcase
  end

endmodule

>>> sv/sblc_slots.sv
// Key and size memories of the cache slots.
module sblc_slots import sblc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic [$clog2(ENTRIES)-1:0] key_rd_idx,
  input  logic [$clog2(ENTRIES)-1:0] size_rd_idx,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_idx,
  input  logic [31:0]                wr_key,
  input  logic [31:0]                wr_size,
  output logic [31:0]                key_q,
  output logic [31:0]                size_q
);

  logic [31:0] key_mem  [ENTRIES];
  logic [31:0] size_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx]  <= wr_key;
      size_mem[wr_idx] <= wr_size;
    end
    key_q  <= key_mem[key_rd_idx];
    size_q <= size_mem[size_rd_idx];
  end

endmodule

>>> sv/sblc_order.sv
// Recency order memory; unwritten positions read as their own index.
module sblc_order import sblc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [$clog2(ENTRIES)-1:0] rd_pos,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_pos,
  input  logic [$clog2(ENTRIES)-1:0] wr_slot,
  output logic [$clog2(ENTRIES)-1:0] rd_q
);

  localparam int IW = $clog2(ENTRIES);

  logic [IW-1:0]      ord_mem [ENTRIES];
  logic [ENTRIES-1:0] ord_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_vld_r <= '0;
    end else if (wr_en) begin
      ord_vld_r[wr_pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ord_mem[wr_pos] <= wr_slot;
    end
    rd_q <= ord_vld_r[rd_pos] ? ord_mem[rd_pos] : rd_pos;
  end

endmodule

>>> sv/sblc_ctrl.sv
// Request sequencer: lookup, eviction, insertion and recency update.
module sblc_ctrl import sblc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  in_t                        in_req,
  input  logic [31:0]                budget,
  output logic                       busy,
  output logic                       out_strobe,
  output out_t                       out_res,
  // slot memories
  output logic [$clog2(ENTRIES)-1:0] key_rd_idx,
  output logic [$clog2(ENTRIES)-1:0] size_rd_idx,
  output logic                       slot_wr_en,
  output logic [$clog2(ENTRIES)-1:0] slot_wr_idx,
  output logic [31:0]                slot_wr_key,
  output logic [31:0]                slot_wr_size,
  input  logic [31:0]                key_q,
  input  logic [31:0]                size_q,
  // recency memory
  output logic [$clog2(ENTRIES)-1:0] ord_rd_pos,
  output logic                       ord_wr_en,
  output logic [$clog2(ENTRIES)-1:0] ord_wr_pos,
  output logic [$clog2(ENTRIES)-1:0] ord_wr_slot,
  input  logic [$clog2(ENTRIES)-1:0] ord_q,
  // shared arithmetic unit
  output alu_req_t                   alu_req,
  input  logic [31:0]                alu_res,
  input  logic                       alu_over
);

  localparam int IW = $clog2(ENTRIES);
  localparam int NW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [NW-1:0] FULL = NW'(ENTRIES);

  state_t             state_r, state_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [31:0]        size_r, size_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic               hit_r, hit_nxt;
  logic               stored_r, stored_nxt;
  logic [4:0]         evc_r, evc_nxt;
  logic [31:0]        used_r, used_nxt;
  logic [NW-1:0]      nvalid_r, nvalid_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  out_t               out_res_r, out_res_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [31:0]        nvalid_ext;
  logic               evict_more;

  assign busy        = (state_r != S_IDLE);
  assign out_strobe  = out_strobe_r;
  assign out_res     = out_res_r;
  assign nvalid_ext  = 32'(nvalid_r);
  assign evict_more  = (nvalid_r != '0) && (alu_over || nvalid_r == FULL);

  assign key_rd_idx   = cnt_r;
  assign size_rd_idx  = ord_q;
  assign slot_wr_idx  = ord_q;
  assign slot_wr_key  = key_r;
  assign slot_wr_size = size_r;

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    size_nxt       = size_r;
    cnt_nxt        = cnt_r;
    slot_nxt       = slot_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    stored_nxt     = stored_r;
    evc_nxt        = evc_r;
    used_nxt       = used_r;
    nvalid_nxt     = nvalid_r;
    valid_nxt      = valid_r;
    out_res_nxt    = out_res_r;
    out_strobe_nxt = 1'b0;
    slot_wr_en     = 1'b0;
    ord_rd_pos     = cnt_r;
    ord_wr_en      = 1'b0;
    ord_wr_pos     = pos_r;
    ord_wr_slot    = slot_r;
    alu_req        = '{op: ALU_CHK, a: used_r, b: size_r, limit: budget};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt    = in_req.key_id;
          size_nxt   = in_req.item_size;
          cnt_nxt    = '0;
          hit_nxt    = 1'b0;
          stored_nxt = 1'b0;
          evc_nxt    = '0;
          state_nxt  = S_LK_RD;
        end
      end
      S_LK_RD: state_nxt = S_LK_CHK;
      S_LK_CHK: begin
        // a = 0 turns the unit into a plain size > budget compare
        alu_req.a = '0;
        if (valid_r[cnt_r] && key_q == key_r) begin
          hit_nxt    = 1'b1;
          stored_nxt = 1'b1;
          slot_nxt   = cnt_r;
          cnt_nxt    = '0;
          state_nxt  = S_FD_RD;
        end else if (cnt_r != LAST) begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_LK_RD;
        end else if (alu_over) begin
          // oversized miss empties the cache
          evc_nxt    = nvalid_ext[4:0];
          valid_nxt  = '0;
          nvalid_nxt = '0;
          used_nxt   = '0;
          state_nxt  = S_DONE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_EV_RD;
        end
      end
      S_FD_RD: state_nxt = S_FD_CHK;
      S_FD_CHK: begin
        if (ord_q == slot_r) begin
          pos_nxt   = cnt_r;
          state_nxt = S_SH_RD;
        end else if (cnt_r == LAST) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_FD_RD;
        end
      end
      S_EV_RD: begin
        if (evict_more) begin
          state_nxt = S_EV_CHK;
        end else begin
          if (nvalid_r == '0) begin
            used_nxt = '0;
          end
          cnt_nxt   = '0;
          state_nxt = S_FR_RD;
        end
      end
      S_EV_CHK: begin
        if (valid_r[ord_q]) begin
          slot_nxt  = ord_q;
          state_nxt = S_EV_SUB;
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_EV_RD;
        end
      end
      S_EV_SUB: begin
        alu_req.op        = ALU_SUB;
        alu_req.b         = size_q;
        used_nxt          = alu_res;
        valid_nxt[slot_r] = 1'b0;
        nvalid_nxt        = nvalid_r - NW'(1);
        evc_nxt           = evc_r + 5'd1;
        cnt_nxt           = cnt_r + IW'(1);
        state_nxt         = S_EV_RD;
      end
      S_FR_RD: state_nxt = S_FR_CHK;
      S_FR_CHK: begin
        if (!valid_r[ord_q]) begin
          alu_req.op       = ALU_ADD;
          used_nxt         = alu_res;
          slot_wr_en       = 1'b1;
          valid_nxt[ord_q] = 1'b1;
          nvalid_nxt       = nvalid_r + NW'(1);
          stored_nxt       = 1'b1;
          slot_nxt         = ord_q;
          pos_nxt          = cnt_r;
          state_nxt        = S_SH_RD;
        end else if (cnt_r == LAST) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_FR_RD;
        end
      end
      S_SH_RD: begin
        // move the slot to the newest end, one position per step
        if (pos_r == LAST) begin
          ord_wr_en   = 1'b1;
          ord_wr_pos  = LAST;
          ord_wr_slot = slot_r;
          state_nxt   = S_DONE;
        end else begin
          ord_rd_pos = pos_r + IW'(1);
          state_nxt  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ord_wr_en   = 1'b1;
        ord_wr_pos  = pos_r;
        ord_wr_slot = ord_q;
        pos_nxt     = pos_r + IW'(1);
        state_nxt   = S_SH_RD;
      end
      S_DONE: begin
        out_res_nxt    = '{hit: hit_r, stored: stored_r, evicted_count: evc_r,
                           bytes_in_use: used_r};
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      nvalid_r     <= '0;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      nvalid_r     <= nvalid_nxt;
      valid_r      <= valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    size_r    <= size_nxt;
    cnt_r     <= cnt_nxt;
    slot_r    <= slot_nxt;
    pos_r     <= pos_nxt;
    hit_r     <= hit_nxt;
    stored_r  <= stored_nxt;
    evc_r     <= evc_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

>>> sv/size_budget_lru_cache.sv
// Size-budgeted LRU cache: top level with configuration port.
//
// Usage: drive in_req (key_id, item_size) with start; the item is taken at
// an edge where start is high and busy is low. busy stays high until the
// item is finished. One result per item appears on out_res for exactly one
// cycle with out_strobe high; the receiver cannot hold it off.
// Configuration: byte_budget at address 0 over the APB-style port
// (psel/penable/pwrite/paddr/pwdata, pready always high, prdata readable).
// Write it only while busy is low and no result is pending.
// Operation: one sequencer walks the tag memory, then the recency memory, in
// read/check steps and shares one adder/comparator. The time busy stays high
// depends on the position of the hit or free slot and on the number of
// evictions; out_strobe is high in the first cycle with busy low. One item
// at a time.
// Reset (synchronous, rst_n low): cache empty, recency order identity,
// bytes in use zero, byte_budget 65536. No clearing pass is needed.
module size_budget_lru_cache import sblc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_req,
  output logic        out_strobe,
  output out_t        out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(ENTRIES);

  logic [31:0]   budget_r;
  logic [IW-1:0] key_rd_idx, size_rd_idx, slot_wr_idx;
  logic          slot_wr_en;
  logic [31:0]   slot_wr_key, slot_wr_size, key_q, size_q;
  logic [IW-1:0] ord_rd_pos, ord_wr_pos, ord_wr_slot, ord_q;
  logic          ord_wr_en;
  alu_req_t      alu_req;
  logic [31:0]   alu_res;
  logic          alu_over;

  assign pready = 1'b1;
  // word address bit 2 selects registers beyond the budget
  assign prdata = paddr[2] ? 32'd0 : budget_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      budget_r <= pwdata;
    end
  end

  sblc_alu u_alu (
    .req  (alu_req),
    .res  (alu_res),
    .over (alu_over)
  );

  sblc_slots #(.ENTRIES(ENTRIES)) u_slots (
    .clk         (clk),
    .key_rd_idx  (key_rd_idx),
    .size_rd_idx (size_rd_idx),
    .wr_en       (slot_wr_en),
    .wr_idx      (slot_wr_idx),
    .wr_key      (slot_wr_key),
    .wr_size     (slot_wr_size),
    .key_q       (key_q),
    .size_q      (size_q)
  );

  sblc_order #(.ENTRIES(ENTRIES)) u_order (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_pos  (ord_rd_pos),
    .wr_en   (ord_wr_en),
    .wr_pos  (ord_wr_pos),
    .wr_slot (ord_wr_slot),
    .rd_q    (ord_q)
  );

  sblc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_req       (in_req),
    .budget       (budget_r),
    .busy         (busy),
    .out_strobe   (out_strobe),
    .out_res      (out_res),
    .key_rd_idx   (key_rd_idx),
    .size_rd_idx  (size_rd_idx),
    .slot_wr_en   (slot_wr_en),
    .slot_wr_idx  (slot_wr_idx),
    .slot_wr_key  (slot_wr_key),
    .slot_wr_size (slot_wr_size),
    .key_q        (key_q),
    .size_q       (size_q),
    .ord_rd_pos   (ord_rd_pos),
    .ord_wr_en    (ord_wr_en),
    .ord_wr_pos   (ord_wr_pos),
    .ord_wr_slot  (ord_wr_slot),
    .ord_q        (ord_q),
    .alu_req      (alu_req),
    .alu_res      (alu_res),
    .alu_over     (alu_over)
  );

endmodule

>>> sv/sblc_checker.sv
// Port-level checks for the size-budgeted LRU cache, bound to the top level.
`include "assert_macros.svh"

module sblc_checker import sblc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_res
);

  // an accepted item keeps the block busy in the next cycle
  `SBLC_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy missing after accept")
  // results come as single-cycle pulses once the work is finished
  `SBLC_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy, "result while busy")
  `SBLC_ASSERT_NXT(a_strobe_pulse, clk, rst_n, out_strobe, !out_strobe, "result held twice")
  // a hit evicts nothing and leaves the item stored
  `SBLC_ASSERT_IMP(a_hit_clean, clk, rst_n, out_strobe && out_res.hit,
                   out_res.stored && out_res.evicted_count == 5'd0, "bad hit result")
  // only an oversized miss leaves nothing stored, and it empties the cache
  `SBLC_ASSERT_IMP(a_flush_empty, clk, rst_n, out_strobe && !out_res.stored,
                   !out_res.hit && out_res.bytes_in_use == 32'd0, "bad flush result")

endmodule

bind size_budget_lru_cache sblc_checker u_sblc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);

>>> sim/tb_size_budget_lru_cache.sv
// Self-checking testbench for the size-budgeted LRU cache.
`timescale 1ns / 1ps

module tb_size_budget_lru_cache;
  import sblc_pkg::*;

  localparam int          SLOTS            = 16;
  localparam int          PHASE_ITEMS      = 215;
  localparam int          STALL_LIMIT      = 2000;
  localparam logic [2:0]  ADDR_BYTE_BUDGET = 3'd0;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t res;
  } lookup_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_req = '0;
  logic        out_strobe;
  out_t        out_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the cache contents
  logic        slot_valid [SLOTS];
  logic [31:0] slot_key   [SLOTS];
  logic [31:0] slot_size  [SLOTS];
  logic [3:0]  lru_order  [SLOTS];
  logic [31:0] bytes_used;
  logic [31:0] model_budget;

  out_t        pending_res [$];
  lookup_row_t directed_rows [$];
  int          fail_count = 0;
  int          stall_cycles = 0;
  bit          no_idle = 1'b0;

  always #6 clk = ~clk;

  size_budget_lru_cache #(.ENTRIES(SLOTS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  function automatic void promote(input logic [3:0] slot);
    int p;
    p = 0;
    while (p < SLOTS && lru_order[p] != slot) p++;
    if (p < SLOTS) begin
      for (; p + 1 < SLOTS; p++) lru_order[p] = lru_order[p + 1];
      lru_order[SLOTS - 1] = slot;
    end
  endfunction

  function automatic out_t predict_lookup(input in_t req);
    out_t        res;
    int          hit_slot;
    int          live;
    logic [4:0]  evicted;
    logic [32:0] need;
    logic [3:0]  s;
    res = '0;
    hit_slot = -1;
    evicted = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && slot_key[i] == req.key_id) begin
        hit_slot = i;
        break;
      end
    end
    if (hit_slot >= 0) begin
      promote(hit_slot[3:0]);
      res.hit = 1'b1;
      res.stored = 1'b1;
    end else if (req.item_size > model_budget) begin
      // oversized: flush everything, store nothing
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i]) begin
          slot_valid[i] = 1'b0;
          evicted++;
        end
      end
      bytes_used = '0;
    end else begin
      live = 0;
      for (int i = 0; i < SLOTS; i++) if (slot_valid[i]) live++;
      need = {1'b0, bytes_used} + {1'b0, req.item_size};
      while (live > 0 && (need > {1'b0, model_budget} || live >= SLOTS)) begin
        for (int p = 0; p < SLOTS; p++) begin
          s = lru_order[p];
          if (slot_valid[s]) begin
            slot_valid[s] = 1'b0;
            bytes_used = bytes_used - slot_size[s];
            break;
          end
        end
        live--;
        evicted++;
        need = {1'b0, bytes_used} + {1'b0, req.item_size};
      end
      if (live == 0) bytes_used = '0;
      // oldest free slot in recency order is reused
      for (int p = 0; p < SLOTS; p++) begin
        s = lru_order[p];
        if (!slot_valid[s]) begin
          slot_valid[s] = 1'b1;
          slot_key[s] = req.key_id;
          slot_size[s] = req.item_size;
          bytes_used = bytes_used + req.item_size;
          promote(s);
          res.stored = 1'b1;
          break;
        end
      end
    end
    res.evicted_count = evicted;
    res.bytes_in_use = bytes_used;
    return res;
  endfunction

  task automatic add_row(input logic [31:0] key, input logic [31:0] size, input bit typed,
                         input logic hit, input logic stored, input logic [4:0] evicted,
                         input logic [31:0] bytes);
    lookup_row_t row;
    row.req.key_id = key;
    row.req.item_size = size;
    row.typed = typed;
    row.res.hit = hit;
    row.res.stored = stored;
    row.res.evicted_count = evicted;
    row.res.bytes_in_use = bytes;
    directed_rows.push_back(row);
  endtask

  // Present one item, wait for it to be taken, then maybe idle for a while.
  task automatic issue(input in_t req, input bit typed, input out_t typed_res);
    out_t res;
    in_req <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    res = predict_lookup(req);
    pending_res.push_back(typed ? typed_res : res);
    if (!no_idle && $urandom_range(99) < 36) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 36);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_budget(input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_BYTE_BUDGET;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    model_budget = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== model_budget) begin
      $error("byte_budget: expected %0d, got %0d", model_budget, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(20);
    if (r < 80) return 32'hFFFF_FFFC + $urandom_range(3);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_size(input logic [31:0] limit);
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 14) return limit;
    if (r < 20) return (limit == 32'hFFFF_FFFF) ? limit : limit + 1;
    if (r < 26) return $urandom();
    if (r < 60) return $urandom_range(limit >> 4);
    return $urandom_range(limit >> 2);
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result item: hit %0d stored %0d evicted %0d bytes %0d",
               out_res.hit, out_res.stored, out_res.evicted_count, out_res.bytes_in_use);
        fail_count++;
      end else begin
        want = pending_res.pop_front();
        if (out_res.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_res.hit);
          fail_count++;
        end
        if (out_res.stored !== want.stored) begin
          $error("stored: expected %0d, got %0d", want.stored, out_res.stored);
          fail_count++;
        end
        if (out_res.evicted_count !== want.evicted_count) begin
          $error("evicted_count: expected %0d, got %0d",
                 want.evicted_count, out_res.evicted_count);
          fail_count++;
        end
        if (out_res.bytes_in_use !== want.bytes_in_use) begin
          $error("bytes_in_use: expected %0d, got %0d",
                 want.bytes_in_use, out_res.bytes_in_use);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no item taken and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_size_budget_lru_cache NOT OK");
      $finish;
    end
  end

  initial begin
    logic [31:0] budgets [6];
    in_t         req;
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_size[i] = '0;
      lru_order[i] = i[3:0];
    end
    bytes_used = '0;
    model_budget = BUDGET_RESET;

    // directed: basic miss/hit, zero size, exact budget, oversized, full slots
    add_row(32'd1, 32'd100, 1, 0, 1, 0, 32'd100);
    add_row(32'd1, 32'd999, 1, 1, 1, 0, 32'd100);
    add_row(32'd0, 32'd0, 1, 0, 1, 0, 32'd100);
    add_row(32'hFFFF_FFFF, 32'd65536, 0, 0, 0, 0, 0);
    add_row(32'd2, 32'd65537, 1, 0, 0, 5'd2, 32'd0);
    add_row(32'd2, 32'hFFFF_FFFF, 1, 0, 0, 5'd0, 32'd0);
    for (int i = 0; i < SLOTS; i++) add_row(32'd100 + i, 32'd1, 1, 0, 1, 0, i + 1);
    add_row(32'd116, 32'd1, 1, 0, 1, 5'd1, 32'd16);
    add_row(32'd101, 32'd0, 1, 1, 1, 5'd0, 32'd16);
    add_row(32'd0, 32'd0, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) issue(directed_rows[i].req, directed_rows[i].typed,
                                     directed_rows[i].res);

    // budget phases: all ones, 1000, zero, 300, the reset value, then a random one
    budgets = '{32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd300, BUDGET_RESET, 32'd0};
    budgets[5] = $urandom();
    foreach (budgets[ph]) begin
      drain();
      write_budget(budgets[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!no_idle && $urandom_range(49) == 0) drain();
        req.key_id = pick_key();
        req.item_size = pick_size(model_budget);
        issue(req, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb_size_budget_lru_cache OK");
    else $display("tb_size_budget_lru_cache NOT OK");
    $finish;
  end

endmodule
